>>> src/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned CountW     = $clog2(QueueDepth + 1);
  localparam int unsigned IdxW       = $clog2(QueueDepth);

  localparam logic OpInsert = 1'b0;
  localparam logic OpPop    = 1'b1;

  typedef struct packed {
    logic        operation;
    logic [15:0] priority_req;
    logic [15:0] entry_id;
  } req_t;

  typedef struct packed {
    logic        removed_valid;
    logic [15:0] removed_priority;
    logic [15:0] removed_id;
    logic        rejected;
    logic [4:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic [15:0] prio;
    logic [15:0] id;
  } entry_t;

  // Per-cell control for one insert step.
  typedef struct packed {
    logic load_new;
    logic shift_in;
  } cell_ctrl_t;

endpackage

>>> src/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps

// Sorted priority queue of spq_pkg::QueueDepth entries held in a row of cells,
// ascending by priority with equal priorities in arrival order. On every request
// transaction all cells compare their priority with the new one and either
// keep their entry, load the new entry, or take their lower neighbor's entry, so
// an insert lands in one step. A pop returns the tail entry and the count after
// the operation; a full insert or an empty pop is flagged as rejected. A new
// request is taken each cycle while the one-entry response register is empty
// or being drained, so throughput is one item per cycle.
module sorted_priority_queue_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  spq_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output spq_pkg::rsp_t out_data_o
);

  localparam int unsigned Depth  = spq_pkg::QueueDepth;
  localparam int unsigned CountW = spq_pkg::CountW;
  localparam int unsigned IdxW   = spq_pkg::IdxW;

  logic [CountW-1:0]   count_q, count_d;
  logic                out_valid_q;
  spq_pkg::rsp_t       out_data_q, rsp_d;

  spq_pkg::entry_t     new_entry;
  spq_pkg::entry_t     entries [Depth];
  spq_pkg::cell_ctrl_t ctrl [Depth];
  logic [Depth-1:0]    le, stays;
  logic                accept, full, empty, insert_en;
  logic [IdxW-1:0]     tail_idx;

  assign in_stall_o  = out_valid_q & out_stall_i;
  assign accept      = in_valid_i & ~in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign full      = (count_q == CountW'(Depth));
  assign empty     = (count_q == '0);
  assign insert_en = accept & (in_data_i.operation == spq_pkg::OpInsert) & ~full;
  assign tail_idx  = IdxW'(count_q - CountW'(1));

  assign new_entry.prio = in_data_i.priority_req;
  assign new_entry.id   = in_data_i.entry_id;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    // Occupied cells whose priority is not above the new one form a prefix.
    assign stays[i] = (CountW'(i) < count_q) & le[i];

    if (i == 0) begin : g_head
      assign ctrl[i].load_new = insert_en & ~stays[i];
      assign ctrl[i].shift_in = 1'b0;
      spq_cell u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (ctrl[i]),
        .left_i  (new_entry),
        .new_i   (new_entry),
        .entry_o (entries[i]),
        .le_o    (le[i])
      );
    end else begin : g_body
      assign ctrl[i].load_new = insert_en & ~stays[i] & stays[i-1];
      assign ctrl[i].shift_in = insert_en & ~stays[i] & ~stays[i-1];
      spq_cell u_cell (
        .clk_i   (clk_i),
        .ctrl_i  (ctrl[i]),
        .left_i  (entries[i-1]),
        .new_i   (new_entry),
        .entry_o (entries[i]),
        .le_o    (le[i])
      );
    end
  end

  always_comb begin
    count_d = count_q;
    rsp_d   = '0;
    if (in_data_i.operation == spq_pkg::OpInsert) begin
      if (full) begin
        rsp_d.rejected = 1'b1;
      end else begin
        count_d = count_q + CountW'(1);
      end
    end else begin
      if (empty) begin
        rsp_d.rejected = 1'b1;
      end else begin
        count_d                = count_q - CountW'(1);
        rsp_d.removed_valid    = 1'b1;
        rsp_d.removed_priority = entries[tail_idx].prio;
        rsp_d.removed_id       = entries[tail_idx].id;
      end
    end
    rsp_d.entry_count = 5'(count_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= rsp_d;
    end
  end

endmodule

>>> src/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell (
  input  logic               clk_i,
  input  spq_pkg::cell_ctrl_t ctrl_i,
  input  spq_pkg::entry_t    left_i,
  input  spq_pkg::entry_t    new_i,
  output spq_pkg::entry_t    entry_o,
  output logic               le_o
);

  spq_pkg::entry_t entry_q;
  spq_pkg::entry_t entry_d;

  // The stored entry stays in place when its priority does not exceed the new one.
  assign le_o    = (entry_q.prio <= new_i.prio);
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load_new) begin
      entry_d = new_i;
    end else if (ctrl_i.shift_in) begin
      entry_d = left_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
